// ----- hdl/ffha_pkg.sv -----
// Package for the first-fit heap allocator: request/result structs and
// constants. Depends on nothing.
package ffha_pkg;

    localparam int ARENA_BYTES_DEF  = 65536;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int LIMIT_W          = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_OOM  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] request_bytes;
        logic [15:0] block_address;
    } t_request;

    typedef struct packed {
        logic [15:0] payload_address;
        logic        status;
    } t_result;

endpackage

// ----- hdl/first_fit_heap_allocator.sv -----
// First-fit heap allocator top level: sequencer, break pointer, limit register.
// Depends on ffha_pkg and ffha_ram.
//
// Usage: drive i_req and pulse i_start while o_busy is low; the request is
// taken at that edge. The result is on o_res when o_done is high.
// An allocate walks the header chain from offset 0 to the break pointer, each
// header taking a read state and then a compare state, using a single shared
// adder and one header RAM port; a split or a grow of the break adds a further
// state. A release of address 0 does nothing; otherwise a release first walks
// to the target header (skipped below the header size), then walks the whole
// chain again, a read state and a merge state per step, merging adjacent free
// pairs. There is no overlap between requests; a new request may be taken in
// the strobe cycle.
// A write on i_cfg_we updates the arena limit; do this only while idle.
// Reset clears the break pointer (empty heap) and sets the limit to 65536.
// The header RAM is not cleared: only headers on the chain are ever read.
// Results cannot be stalled by the receiver; o_done is a one-cycle strobe.
module first_fit_heap_allocator #(
    parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  ffha_pkg::t_request           i_req,
    output logic                         o_done,
    output ffha_pkg::t_result            o_res,
    input  logic                         i_cfg_we,
    input  logic [ffha_pkg::LIMIT_W-1:0] i_cfg_data
);
    localparam int SLOTS  = (ARENA_BYTES + 7) / 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW     = $clog2(ARENA_BYTES) + 1;   // pointer width, holds ARENA_BYTES
    localparam int SW     = PW;                        // stored size width
    localparam int HW     = SW + 1;                    // size plus free bit
    localparam int CW     = 34;                        // compare width

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ARD   = 4'd1;
    localparam logic [3:0] S_AEV   = 4'd2;
    localparam logic [3:0] S_ASPL  = 4'd3;
    localparam logic [3:0] S_AGROW = 4'd4;
    localparam logic [3:0] S_RRD   = 4'd5;
    localparam logic [3:0] S_REV   = 4'd6;
    localparam logic [3:0] S_MRDH  = 4'd7;
    localparam logic [3:0] S_MWH   = 4'd8;
    localparam logic [3:0] S_MRDN  = 4'd9;
    localparam logic [3:0] S_MWN   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]                   r_state, n_state;
    logic [PW-1:0]                r_brk, n_brk;
    logic [ffha_pkg::LIMIT_W-1:0] r_lim;
    logic [PW-1:0]                r_h, n_h;
    logic [PW-1:0]                r_n, n_n;
    logic [CW-1:0]                r_req, n_req;
    logic [PW-1:0]                r_tgt, n_tgt;
    logic [SW-1:0]                r_hsz, n_hsz;
    logic                         r_hfree, n_hfree;
    ffha_pkg::t_result            r_res, n_res;
    logic                         r_done, n_done;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_addr;
    logic [HW-1:0]         ram_wdata, ram_rdata;
    logic [SW-1:0]         rd_size;
    logic                  rd_free;
    logic [CW-1:0]         sum;

    assign rd_size = ram_rdata[HW-1:1];
    assign rd_free = ram_rdata[0];

    ffha_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_hdr (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Shared adder: header offset + header + size.
    logic [CW-1:0] add_a, add_b;
    assign sum = add_a + add_b + CW'(HEADER_BYTES);

    function automatic logic [SLOT_W-1:0] slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = p >> 3;
        return s[SLOT_W-1:0];
    endfunction

    logic [CW-1:0] req_raw;
    logic [CW-1:0] lim_now;
    assign lim_now = (CW'(r_lim) > CW'(ARENA_BYTES)) ? CW'(ARENA_BYTES) : CW'(r_lim);

    always_comb begin
        n_state = r_state; n_brk = r_brk; n_h = r_h; n_n = r_n; n_req = r_req;
        n_tgt = r_tgt; n_hsz = r_hsz; n_hfree = r_hfree; n_res = r_res;
        n_done = 1'b0;
        ram_we = 1'b0; ram_addr = slot(r_h); ram_wdata = '0;
        add_a = CW'(r_h); add_b = CW'(rd_size);
        req_raw = (i_req.request_bytes == 32'd0) ? CW'(1) : CW'(i_req.request_bytes);
        case (r_state)
            S_IDLE: begin
                ram_addr = '0;
                if (i_start) begin
                    n_h = '0;
                    n_res.payload_address = '0;
                    n_res.status = ffha_pkg::ST_DONE;
                    if (i_req.action == ffha_pkg::ACT_ALLOC) begin
                        n_req = (req_raw + CW'(7)) & ~CW'(7);
                        if (req_raw > CW'(32'hFFFF_FFFF - 32'd7 - 32'(HEADER_BYTES))) begin
                            n_res.status = ffha_pkg::ST_OOM;
                            n_state = S_DONE;
                        end else if (r_brk == '0) begin
                            n_state = S_AGROW;
                        end else begin
                            n_state = S_ARD;
                        end
                    end else if (i_req.block_address == 16'd0) begin
                        n_state = S_DONE;
                    end else if (CW'(i_req.block_address) < CW'(HEADER_BYTES)) begin
                        n_state = S_MRDH;
                    end else begin
                        n_tgt = PW'(CW'(i_req.block_address) - CW'(HEADER_BYTES));
                        n_state = (r_brk == '0) ? S_DONE : S_RRD;
                    end
                end
            end
            // Read cycle: RAM address is the current header.
            S_ARD: n_state = S_AEV;
            S_AEV: begin
                n_hsz = rd_size;
                n_n = PW'(sum);
                if (rd_free && CW'(rd_size) >= r_req) begin
                    n_res.payload_address = 16'(CW'(r_h) + CW'(HEADER_BYTES));
                    if (CW'(rd_size) >= r_req + CW'(HEADER_BYTES + 8)) begin
                        ram_wdata = {SW'(r_req), 1'b0};
                        n_state = S_ASPL;
                    end else begin
                        ram_wdata = {rd_size, 1'b0};
                        n_state = S_DONE;
                    end
                    ram_we = 1'b1;
                end else if (sum >= CW'(r_brk)) begin
                    n_state = S_AGROW;
                end else begin
                    n_h = PW'(sum);
                    n_state = S_ARD;
                end
            end
            S_ASPL: begin
                add_b = r_req;
                ram_addr = slot(PW'(sum));
                ram_we = 1'b1;
                ram_wdata = {SW'(CW'(r_hsz) - r_req - CW'(HEADER_BYTES)), 1'b1};
                n_state = S_DONE;
            end
            S_AGROW: begin
                add_a = CW'(r_brk); add_b = r_req;
                ram_addr = slot(r_brk);
                if (sum > lim_now) begin
                    n_res.status = ffha_pkg::ST_OOM;
                end else begin
                    ram_we = 1'b1;
                    ram_wdata = {SW'(r_req), 1'b0};
                    n_res.payload_address = 16'(CW'(r_brk) + CW'(HEADER_BYTES));
                    n_brk = PW'(sum);
                end
                n_state = S_DONE;
            end
            S_RRD: n_state = S_REV;
            S_REV: begin
                if (r_h == r_tgt) begin
                    ram_we = 1'b1;
                    ram_wdata = {rd_size, 1'b1};
                    n_h = '0;
                    n_state = S_MRDH;
                end else if (sum >= CW'(r_brk) || sum > CW'(r_tgt)) begin
                    n_h = '0;
                    n_state = S_MRDH;
                end else begin
                    n_h = PW'(sum);
                    n_state = S_RRD;
                end
            end
            // Merge walk: read h, then read next; merge or advance.
            S_MRDH: begin
                n_state = (r_brk == '0) ? S_DONE : S_MWH;
            end
            S_MWH: begin
                n_hsz = rd_size; n_hfree = rd_free;
                n_n = PW'(sum);
                n_state = (sum >= CW'(r_brk)) ? S_DONE : S_MRDN;
            end
            S_MRDN: begin
                ram_addr = slot(r_n);
                n_state = S_MWN;
            end
            // The block after the merged one starts where the absorbed block's
            // successor started, so the next offset is the same on both paths.
            S_MWN: begin
                ram_addr = slot(r_h);
                add_a = CW'(r_n);
                n_n = PW'(sum);
                n_state = (sum >= CW'(r_brk)) ? S_DONE : S_MRDN;
                if (r_hfree && rd_free) begin
                    ram_we = 1'b1;
                    ram_wdata = {SW'(CW'(r_hsz) + CW'(HEADER_BYTES) + CW'(rd_size)), 1'b1};
                    n_hsz = SW'(CW'(r_hsz) + CW'(HEADER_BYTES) + CW'(rd_size));
                end else begin
                    n_h = r_n;
                    n_hsz = rd_size; n_hfree = rd_free;
                end
            end
            S_DONE: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_brk   <= '0;
            r_lim   <= ffha_pkg::LIMIT_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_brk   <= n_brk;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_lim <= i_cfg_data;
            end
        end
        r_h <= n_h; r_n <= n_n; r_req <= n_req; r_tgt <= n_tgt;
        r_hsz <= n_hsz; r_hfree <= n_hfree; r_res <= n_res;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    a_brk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_brk) <= CW'(ARENA_BYTES)) else $error("break beyond arena");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_brk_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_brk == $past(r_brk))) else $error("break moved idle");
endmodule

// ----- hdl/ffha_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
